// File: sv/lstk_pkg.sv
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared types and constants for the bounded lifo stack with one-step reverse.
// ----------------------------------------------------------------------------
package lstk_pkg;

    localparam int DEPTH          = 16;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int FUNC_W         = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH    = 3'd0,
        FN_POP     = 3'd1,
        FN_READ    = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_REVERSE = 3'd4,
        FN_QUERY   = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] push_value;
    } item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] top_value;
        logic                      top_valid;
        logic [CNT_W-1:0]          entry_count;
        logic                      is_empty;
    } result_t;

endpackage

// File: sv/lstk_in_reg.sv
// ----------------------------------------------------------------------------
// lstk_in_reg
// Input register stage: captures one transaction and holds it until the
// stack core takes it.
// ----------------------------------------------------------------------------
module lstk_in_reg (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [lstk_pkg::FUNC_W-1:0]               func,
    input  logic signed [lstk_pkg::VALUE_W-1:0]       push_value,
    input  logic                                      take,
    output logic                                      item_valid,
    output lstk_pkg::item_t                           item
);
    import lstk_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    logic  accept;
    item_t item_reg;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.func       <= func;
            item_reg.push_value <= push_value;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/lstk_core.sv
// ----------------------------------------------------------------------------
// lstk_core
// Stack state: ring store, count, ring base and orientation. Applies one
// operation per fire and registers the result from the state after it.
// ----------------------------------------------------------------------------
module lstk_core #(
    parameter int DATA_WIDTH = lstk_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  lstk_pkg::item_t   item,
    output lstk_pkg::result_t res
);
    import lstk_pkg::*;

    logic [DATA_WIDTH-1:0] store [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] base_next;
    logic             flip_reg;
    logic             flip_next;

    func_t                 op;
    status_t               status;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_slot;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [IDX_W-1:0]      rd_slot;
    logic                  non_empty;

    status_t               status_reg;
    logic [DATA_WIDTH-1:0] top_word_reg;
    logic                  top_valid_reg;
    logic [CNT_W-1:0]      entry_count_reg;

    assign op      = func_t'(item.func);
    assign wr_word = DATA_WIDTH'($unsigned(item.push_value));

    always_comb
    begin
        count_next = count_reg;
        base_next  = base_reg;
        flip_next  = flip_reg;
        wr_en      = 1'b0;
        wr_slot    = base_reg + count_reg[IDX_W-1:0];
        status     = ST_OK;
        unique case (op)
            FN_PUSH:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (flip_reg)
                    begin
                        base_next = base_reg - 1'b1;
                        wr_slot   = base_reg - 1'b1;
                    end
                end
            end
            FN_POP:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (flip_reg)
                    begin
                        base_next = base_reg + 1'b1;
                    end
                end
            end
            FN_READ:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
            end
            FN_CLEAR:
            begin
                count_next = '0;
            end
            FN_REVERSE:
            begin
                flip_next = !flip_reg;
            end
            default:
            begin
            end
        endcase
    end

    // top slot after the operation; a fresh push is forwarded
    assign rd_slot   = flip_next ? base_next
                                 : base_next + count_next[IDX_W-1:0] - 1'b1;
    assign non_empty = (count_next != '0);

    always_comb
    begin
        res.status      = status_reg;
        res.top_value   = top_valid_reg ? VALUE_W'(signed'(top_word_reg)) : '0;
        res.top_valid   = top_valid_reg;
        res.entry_count = entry_count_reg;
        res.is_empty    = !top_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            base_reg  <= '0;
            flip_reg  <= 1'b0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            base_reg  <= base_next;
            flip_reg  <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (wr_en)
            begin
                store[wr_slot] <= wr_word;
            end
            top_word_reg    <= wr_en ? wr_word : store[rd_slot];
            status_reg      <= status;
            top_valid_reg   <= non_empty;
            entry_count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op == FN_PUSH && count_reg != CNT_W'(DEPTH)
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("push did not grow the stack");

    a_reverse_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op == FN_REVERSE |=> flip_reg != $past(flip_reg))
        else $error("reverse did not toggle orientation");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg) && $stable(base_reg) && $stable(flip_reg))
        else $error("stack state changed without a transaction");

endmodule

// File: sv/lifo_stack_with_reverse.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_reverse
// Bounded lifo stack of signed words with push, pop, read, clear, reverse
// and query; reverse toggles the ring orientation instead of moving words.
// ----------------------------------------------------------------------------
// pipeline: input register, then result register; the stack update sits
//   between the two
// throughput: one transaction per cycle, sustained under no output stall
// reset: clears count, ring base, orientation and both valid flags at once;
//   store words are undefined until pushed
// ----------------------------------------------------------------------------
module lifo_stack_with_reverse #(
    parameter int DATA_WIDTH = lstk_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lstk_pkg::FUNC_W-1:0]         func,
    input  logic signed [lstk_pkg::VALUE_W-1:0] push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lstk_pkg::STATUS_W-1:0]       status,
    output logic signed [lstk_pkg::VALUE_W-1:0] top_value,
    output logic                                top_valid,
    output logic [lstk_pkg::CNT_W-1:0]          entry_count,
    output logic                                is_empty
);
    import lstk_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    out_load;
    logic    take;
    result_t res;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign out_load = !out_valid_reg || !out_stall;
    assign take     = item_valid && out_load;

    lstk_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .push_value (push_value),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    lstk_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (take),
        .item  (item),
        .res   (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res.status;
    assign top_value   = res.top_value;
    assign top_valid   = res.top_valid;
    assign entry_count = res.entry_count;
    assign is_empty    = res.is_empty;

endmodule
